// File: sv/pcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types and constants of the packed counter multiset.
// ----------------------------------------------------------------------------
package pcm_pkg;

    localparam int unsigned STORE_BYTES = 1024;
    localparam int unsigned BYTE_BITS   = 8;
    localparam int unsigned STORE_BITS  = STORE_BYTES * BYTE_BITS;

    // The byte store is split into an even and an odd bank so that the two
    // bytes a counter may span are read and written in the same cycle.
    localparam int unsigned BANK_DEPTH  = (STORE_BYTES + 1) / 2;
    localparam int unsigned BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int unsigned BYTE_W      = (BANK_AW + 1 > 14) ? BANK_AW + 1 : 14;

    localparam int unsigned VALUE_W     = 13;
    localparam int unsigned CWIDTH_W    = 4;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned BITPOS_W    = VALUE_W + CWIDTH_W;
    localparam int unsigned CFG_DATA_W  = 13;

    localparam logic [VALUE_W-1:0]  MAX_VALUE_RST   = 13'd1023;
    localparam logic [CWIDTH_W-1:0] COUNT_WIDTH_RST = 4'd8;
    localparam logic [CWIDTH_W-1:0] COUNT_WIDTH_MAX = 4'd8;

    typedef enum logic {
        ACT_ADD   = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        REG_MAX_VALUE   = 1'b0,
        REG_COUNT_WIDTH = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD
    } t_state;

endpackage
`default_nettype wire

// File: sv/pcm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_if
// Valid/ready channels of the packed counter multiset: requests, results
// and configuration writes.
// ----------------------------------------------------------------------------
interface pcm_in_if import pcm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               action;
    logic [VALUE_W-1:0] value;

    modport source (output valid, action, value, input ready);
    modport sink   (input valid, action, value, output ready);
endinterface

interface pcm_out_if import pcm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] occurrences;
    logic [1:0]         status;

    modport source (output valid, occurrences, status, input ready);
    modport sink   (input valid, occurrences, status, output ready);
endinterface

interface pcm_cfg_if import pcm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/pcm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module pcm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 512,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: sv/packed_counter_multiset.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packed_counter_multiset
// Multiset of small values kept as bit-packed counters in a byte store.
// ----------------------------------------------------------------------------
// Flow: an accepted request reads both store banks, then writes them back and
// registers its result; no new request is taken until the write-back is done,
// and a stalled result holds the next write-back.
// Reset: the store is zeroed by a pass over all BANK_DEPTH (512) rows, one row
// of both banks per cycle; no request is accepted until it ends, while
// configuration writes are taken throughout.
module packed_counter_multiset import pcm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pcm_in_if.sink    i_in,
    pcm_out_if.source o_out,
    pcm_cfg_if.sink   i_cfg
);

    t_state                r_state, n_state;
    logic [BANK_AW-1:0]    r_clr_addr;
    logic [VALUE_W-1:0]    r_max_value;
    logic [CWIDTH_W-1:0]   r_count_width;

    // Request held between the read and the write-back.
    t_action               r_action;
    logic                  r_err;
    logic [2:0]            r_offset;
    logic [COUNT_W-1:0]    r_full;
    logic                  r_odd;
    logic                  r_hi_ok;
    logic [BANK_AW-1:0]    r_even_addr;
    logic [BANK_AW-1:0]    r_odd_addr;

    logic                  r_out_valid;
    logic [COUNT_W-1:0]    r_occ;
    t_status               r_status;

    // Configuration fit and address arithmetic.
    logic [17:0]           need_bits;
    logic                  fits;
    logic [BITPOS_W-1:0]   bit_at;
    logic [BYTE_W-1:0]     byte_at;
    logic [BANK_AW-1:0]    lo_row;
    logic                  in_fire;
    logic                  go;

    // Read-modify-write datapath.
    logic [COUNT_W-1:0]    even_rd, odd_rd;
    logic [15:0]           word, mask, new_word;
    logic [COUNT_W-1:0]    cnt, cnt_inc;
    logic                  is_full;
    logic                  do_write;

    logic                  even_en, even_we, odd_en, odd_we;
    logic [BANK_AW-1:0]    even_addr, odd_addr;
    logic [COUNT_W-1:0]    even_wdata, odd_wdata;

    assign need_bits = 18'(({5'b0, r_max_value} + 18'd1) * {14'b0, r_count_width});
    assign fits      = (r_count_width != '0) && (r_count_width <= COUNT_WIDTH_MAX)
                       && (32'(need_bits) <= STORE_BITS);

    assign bit_at  = BITPOS_W'({4'b0, i_in.value} * {13'b0, r_count_width});
    assign byte_at = BYTE_W'(bit_at >> 3);
    assign lo_row  = byte_at[BANK_AW:1];

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign go         = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;

    assign word     = r_odd ? {even_rd, odd_rd} : {odd_rd, even_rd};
    assign cnt      = COUNT_W'(word >> r_offset) & r_full;
    assign cnt_inc  = cnt + 8'd1;
    assign is_full  = (cnt >= r_full);
    assign mask     = {8'b0, r_full} << r_offset;
    assign new_word = (word & ~mask) | ({8'b0, cnt_inc} << r_offset);
    assign do_write = !r_err && (r_action == ACT_ADD) && !is_full;

    always_comb begin
        n_state    = r_state;
        even_en    = 1'b0;
        even_we    = 1'b0;
        odd_en     = 1'b0;
        odd_we     = 1'b0;
        even_addr  = r_even_addr;
        odd_addr   = r_odd_addr;
        even_wdata = r_odd ? new_word[15:8] : new_word[7:0];
        odd_wdata  = r_odd ? new_word[7:0] : new_word[15:8];
        case (r_state)
            S_CLEAR: begin
                even_en    = 1'b1;
                even_we    = 1'b1;
                odd_en     = 1'b1;
                odd_we     = 1'b1;
                even_addr  = r_clr_addr;
                odd_addr   = r_clr_addr;
                even_wdata = '0;
                odd_wdata  = '0;
                if (r_clr_addr == BANK_AW'(BANK_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // For an odd first byte the upper byte sits in the next even row.
                even_addr = byte_at[0] ? lo_row + 1'b1 : lo_row;
                odd_addr  = lo_row;
                if (in_fire) begin
                    even_en = 1'b1;
                    odd_en  = 1'b1;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (go) begin
                    even_en = do_write && (!r_odd || r_hi_ok);
                    even_we = even_en;
                    odd_en  = do_write && (r_odd || r_hi_ok);
                    odd_we  = odd_en;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_max_value   <= MAX_VALUE_RST;
            r_count_width <= COUNT_WIDTH_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg.valid) begin
                case (t_cfg_reg'(i_cfg.index))
                    REG_MAX_VALUE:   r_max_value   <= i_cfg.data[VALUE_W-1:0];
                    REG_COUNT_WIDTH: r_count_width <= i_cfg.data[CWIDTH_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_MOD && go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action    <= t_action'(i_in.action);
            r_err       <= !fits || (i_in.value > r_max_value);
            r_offset    <= bit_at[2:0];
            r_full      <= COUNT_W'((9'd1 << r_count_width) - 9'd1);
            r_odd       <= byte_at[0];
            r_hi_ok     <= (32'(byte_at) + 32'd1) < STORE_BYTES;
            r_even_addr <= even_addr;
            r_odd_addr  <= odd_addr;
        end
        if (r_state == S_MOD && go) begin
            if (r_err) begin
                r_occ    <= '0;
                r_status <= ST_RANGE;
            end else if (r_action == ACT_QUERY) begin
                r_occ    <= cnt;
                r_status <= ST_OK;
            end else if (is_full) begin
                r_occ    <= cnt;
                r_status <= ST_FULL;
            end else begin
                r_occ    <= cnt_inc;
                r_status <= ST_OK;
            end
        end
    end

    pcm_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .i_clk   (i_clk),
        .i_en    (even_en),
        .i_we    (even_we),
        .i_addr  (even_addr),
        .i_wdata (even_wdata),
        .o_rdata (even_rd)
    );

    pcm_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .i_clk   (i_clk),
        .i_en    (odd_en),
        .i_we    (odd_we),
        .i_addr  (odd_addr),
        .i_wdata (odd_wdata),
        .o_rdata (odd_rd)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.occurrences = r_occ;
    assign o_out.status      = r_status;

endmodule
`default_nettype wire
